// ----- rtl/sharpen_filter_with_luma_histogram_unit_defines.svh -----
// Assertion macros for the sharpen filter with luma histogram.
// Uses the clk and arst_n names of the module that includes this header.
`ifndef SHARPEN_FILTER_WITH_LUMA_HISTOGRAM_UNIT_DEFINES_SVH
`define SHARPEN_FILTER_WITH_LUMA_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sfh_pkg.sv -----
// Shared types and constants of the sharpen filter with luma histogram.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfh_pkg;

	localparam int PIX_W      = 8;
	localparam int PIX_MAX    = 255;
	localparam int CENTER_GAIN = 5;
	localparam int MIN_DIM    = 3;

	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
	localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int JOB_DEPTH = 4;

	// luma = round((2126 R + 7152 G + 722 B) / 10000); the weighted sum tops out
	// at 2550000, which fits 22 bits.
	localparam int WT_R   = 2126;
	localparam int WT_G   = 7152;
	localparam int WT_B   = 722;
	localparam int LUMA_W = 22;
	localparam int LUMA_SCALE = 1000;
	localparam int LUMA_DIGIT = 10;
	localparam int LUMA_HALF  = 5;

	// round(sum / 10000) < L  <=>  sum < (10 L - 5) * 1000, so the bins come
	// straight from the weighted sum with no divider.
	localparam logic [LUMA_W-1:0] LUMA_TH0 = LUMA_W'((51 * LUMA_DIGIT - LUMA_HALF) * LUMA_SCALE);
	localparam logic [LUMA_W-1:0] LUMA_TH1 = LUMA_W'((102 * LUMA_DIGIT - LUMA_HALF) * LUMA_SCALE);
	localparam logic [LUMA_W-1:0] LUMA_TH2 = LUMA_W'((153 * LUMA_DIGIT - LUMA_HALF) * LUMA_SCALE);
	localparam logic [LUMA_W-1:0] LUMA_TH3 = LUMA_W'((204 * LUMA_DIGIT - LUMA_HALF) * LUMA_SCALE);

	localparam int BIN_W    = 3;
	localparam int NUM_BINS = 5;
	localparam logic [BIN_W-1:0] BIN_0 = 3'd0;
	localparam logic [BIN_W-1:0] BIN_1 = 3'd1;
	localparam logic [BIN_W-1:0] BIN_2 = 3'd2;
	localparam logic [BIN_W-1:0] BIN_3 = 3'd3;
	localparam logic [BIN_W-1:0] BIN_4 = 3'd4;

	localparam int CNT_W = 23;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	// One accepted pixel, classified: what it releases and the window it needs.
	typedef struct packed {
		logic clr;    // first pixel of a frame: bins restart
		logic emit1;  // releases the pixel one row up
		logic sharp;  // that pixel is interior and gets filtered
		logic emit2;  // last row: releases itself too
		logic last;   // last column
		rgb_t up;
		rgb_t left;
		rgb_t mid;
		rgb_t right;
		rgb_t down;
	} job_t;

endpackage

// ----- rtl/sharpen_filter_with_luma_histogram_unit.sv -----
// Sharpen filter with luma histogram: usage notes.
// Input: push an RGB pixel of one frame in raster order whenever full is low.
// Output: while empty is low the oldest result sits on out_*, grey_bin,
//   frame_last and bin0..bin4_count; pop takes it. The counts include it.
// Config: cfg_wr_en writes image_width (index 0) or image_height (index 1); the user
//   must write only while idle (not enforced); full rises for one cycle after each write.
// A pixel of row y releases row y-1's pixel; on the last row it also
//   releases itself, so the frame ends with its own pixels.
// Pipeline: a result reaches the ports from the transfer of the pixel that
//   releases it through the job queue, window stage, filter, luma sum and bin
//   into the result register; a last-row pixel's second result follows it.
// Throughput: one pixel per cycle while the receiver keeps up; on the last row two
//   results per pixel pass the single result register, so the job queue can fill there.
// Reset: positions, bins and queues clear; line store contents stay
//   undefined and are only used after being written; full is high for the
//   first cycle while the line store read-ahead primes.
// Receiver stall: the back pipeline holds, the 4-entry job queue fills and
//   then full rises; no transfer is lost on either side.
`timescale 1ns / 1ps
`include "sharpen_filter_with_luma_histogram_unit_defines.svh"

module sharpen_filter_with_luma_histogram_unit import sfh_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [PIX_W-1:0]      in_r,
	input  logic [PIX_W-1:0]      in_g,
	input  logic [PIX_W-1:0]      in_b,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIX_W-1:0]      out_r,
	output logic [PIX_W-1:0]      out_g,
	output logic [PIX_W-1:0]      out_b,
	output logic [BIN_W-1:0]      grey_bin,
	output logic                  frame_last,
	output logic [CNT_W-1:0]      bin0_count,
	output logic [CNT_W-1:0]      bin1_count,
	output logic [CNT_W-1:0]      bin2_count,
	output logic [CNT_W-1:0]      bin3_count,
	output logic [CNT_W-1:0]      bin4_count
);

	logic [IMG_W_W-1:0] img_w_q;
	logic [IMG_H_W-1:0] img_h_q;

	job_t job_in, job_out;
	logic job_push, job_full, job_take, job_avail;

	// geometry registers, written straight from the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMG_W_RESET;
			img_h_q <= IMG_H_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					img_w_q <= cfg_data[IMG_W_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					img_h_q <= cfg_data[IMG_H_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: position tracking, line stores, window and classification
	sfh_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (img_w_q),
		.image_height (img_h_q),
		.cfg_wr       (cfg_wr_en),
		.push         (push),
		.full         (full),
		.in_r         (in_r),
		.in_g         (in_g),
		.in_b         (in_b),
		.job          (job_in),
		.job_push     (job_push),
		.queue_full   (job_full)
	);

	// decouples the pixel input from the result side
	sfh_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_take),
		.rdata  (job_out),
		.avail  (job_avail)
	);

	// back: filter, luma, histogram and result register
	sfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_out),
		.job_valid  (job_avail),
		.job_take   (job_take),
		.pop        (pop),
		.empty      (empty),
		.out_r      (out_r),
		.out_g      (out_g),
		.out_b      (out_b),
		.grey_bin   (grey_bin),
		.frame_last (frame_last),
		.bin0_count (bin0_count),
		.bin1_count (bin1_count),
		.bin2_count (bin2_count),
		.bin3_count (bin3_count),
		.bin4_count (bin4_count)
	);

	// a config write must refresh the line store read-ahead before the next pixel
	`SFH_ASSERT_NEXT(a_cfg_refresh, cfg_wr_en, full, "pixel taken on stale line store read")

	// every pixel transfer lands in the job queue
	`SFH_ASSERT_NEXT(a_job_queued, push && !full, job_avail, "accepted pixel not queued")

	// the shown bin has been counted at least once
	`SFH_ASSERT_NOW(a_bin_counted, !empty,
		(grey_bin == BIN_0 && bin0_count != '0) || (grey_bin == BIN_1 && bin1_count != '0)
		|| (grey_bin == BIN_2 && bin2_count != '0) || (grey_bin == BIN_3 && bin3_count != '0)
		|| (grey_bin == BIN_4 && bin4_count != '0),
		"result bin not counted")

endmodule

// ----- rtl/sfh_fifo.sv -----
// Short job queue between the front and the back of the filter.
// Depends on sfh_pkg for job_t.
`timescale 1ns / 1ps

module sfh_fifo import sfh_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	output logic full,
	input  logic rd,
	output job_t rdata,
	output logic avail
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!wr && rd) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign rdata = mem_q[rp_q];
	assign full  = (cnt_q == CW'(DEPTH));
	assign avail = (cnt_q != '0);

endmodule

// ----- rtl/sfh_front.sv -----
// Front of the filter: raster position, line stores, 3x3 cross window, job build.
// Depends on sfh_pkg.
`timescale 1ns / 1ps

module sfh_front import sfh_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IMG_W_W-1:0] image_width,
	input  logic [IMG_H_W-1:0] image_height,
	input  logic               cfg_wr,
	input  logic               push,
	output logic               full,
	input  logic [PIX_W-1:0]   in_r,
	input  logic [PIX_W-1:0]   in_g,
	input  logic [PIX_W-1:0]   in_b,
	output job_t               job,
	output logic               job_push,
	input  logic               queue_full
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);

	logic [AW-1:0] xlast, x_q, x_eff, x_nxt, ra_right;
	logic [HW-1:0] ylast, y_q, y_eff, y_nxt;
	logic          row_end, frame_end, accept, rd_ok_q;
	rgb_t          pix, left_q, rd_mid_q, rd_right_q, rd_up_q;

	rgb_t mid_mem [MAX_WIDTH];
	rgb_t up_mem  [MAX_WIDTH];

	// saturate the geometry registers to the supported range
	always_comb begin
		if (image_width < IMG_W_W'(MIN_DIM)) begin
			xlast = AW'(MIN_DIM - 1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			xlast = AW'(MAX_WIDTH - 1);
		end else begin
			xlast = AW'(image_width - IMG_W_W'(1));
		end
		if (image_height < IMG_H_W'(MIN_DIM)) begin
			ylast = HW'(MIN_DIM - 1);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			ylast = HW'(MAX_HEIGHT - 1);
		end else begin
			ylast = HW'(image_height - IMG_H_W'(1));
		end
	end

	assign x_eff     = (x_q > xlast) ? xlast : x_q;
	assign y_eff     = (y_q > ylast) ? ylast : y_q;
	assign row_end   = (x_eff == xlast);
	assign frame_end = (y_eff == ylast);

	// line store read-ahead must match the current position before a transfer
	assign full   = !rd_ok_q || queue_full;
	assign accept = push && !full;

	always_comb begin
		x_nxt = x_eff;
		y_nxt = y_eff;
		if (accept) begin
			if (row_end) begin
				x_nxt = '0;
				y_nxt = frame_end ? '0 : y_eff + HW'(1);
			end else begin
				x_nxt = x_eff + AW'(1);
			end
		end
	end

	assign ra_right = (x_nxt == xlast) ? x_nxt : x_nxt + AW'(1);

	assign pix.r = in_r;
	assign pix.g = in_g;
	assign pix.b = in_b;

	// middle line read at the next column and its right neighbour; upper line at the next column
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_mem[x_eff] <= pix;
			up_mem[x_eff]  <= rd_mid_q;
		end
		rd_mid_q   <= mid_mem[x_nxt];
		rd_right_q <= mid_mem[ra_right];
		rd_up_q    <= up_mem[x_nxt];
	end

	// the stored position only saturates when a pixel is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			left_q  <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= !cfg_wr;
			if (accept) begin
				x_q    <= x_nxt;
				y_q    <= y_nxt;
				left_q <= rd_mid_q;
			end
		end
	end

	always_comb begin
		job.clr   = (x_eff == '0) && (y_eff == '0);
		job.emit1 = (y_eff != '0);
		job.sharp = !((y_eff == HW'(1)) || (x_eff == '0) || row_end);
		job.emit2 = frame_end;
		job.last  = row_end;
		job.up    = rd_up_q;
		job.left  = left_q;
		job.mid   = rd_mid_q;
		job.right = rd_right_q;
		job.down  = pix;
	end

	assign job_push = accept;

endmodule

// ----- rtl/sfh_back.sv -----
// Back of the filter: result serializer, sharpen, luma, binning, result register.
// Depends on sfh_pkg.
`timescale 1ns / 1ps

module sfh_back import sfh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             job,
	input  logic             job_valid,
	output logic             job_take,
	input  logic             pop,
	output logic             empty,
	output logic [PIX_W-1:0] out_r,
	output logic [PIX_W-1:0] out_g,
	output logic [PIX_W-1:0] out_b,
	output logic [BIN_W-1:0] grey_bin,
	output logic             frame_last,
	output logic [CNT_W-1:0] bin0_count,
	output logic [CNT_W-1:0] bin1_count,
	output logic [CNT_W-1:0] bin2_count,
	output logic [CNT_W-1:0] bin3_count,
	output logic [CNT_W-1:0] bin4_count
);

	typedef struct packed {
		logic live;
		logic vld;
		logic clr;
		logic last;
	} ctl_t;

	function automatic logic [PIX_W-1:0] sharp_ch(input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] l, input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] d);
		logic signed [11:0] gain;
		logic signed [11:0] lim;
		logic signed [11:0] v;
		gain = 12'(CENTER_GAIN);
		lim  = 12'(PIX_MAX);
		v = gain * $signed(12'(c)) - $signed(12'(l)) - $signed(12'(r))
			- $signed(12'(u)) - $signed(12'(d));
		if (v < 12'sd0) begin
			return '0;
		end else if (v > lim) begin
			return PIX_W'(PIX_MAX);
		end
		return v[PIX_W-1:0];
	endfunction

	logic adv, take, phase_q, phase_d;
	ctl_t ctl_d, ctl_s1, ctl_s2, ctl_s3;
	logic sharp_d, sharp_s1;
	rgb_t mid_d;
	rgb_t up_s1, left_s1, mid_s1, right_s1, down_s1;
	rgb_t pix_s2, pix_s3, pix_f;
	logic [LUMA_W-1:0] luma_s3;
	logic [BIN_W-1:0]  bin_d;
	logic [CNT_W-1:0]  cnt_q [NUM_BINS];
	logic [CNT_W-1:0]  cnt_d [NUM_BINS];
	logic [CNT_W-1:0]  base;
	logic              out_vld_q, out_last_q;
	rgb_t              out_pix_q;
	logic [BIN_W-1:0]  out_bin_q;

	assign adv   = !out_vld_q || pop;
	assign empty = !out_vld_q;

	// one job gives up to two results: the pixel above, then on the last row itself
	always_comb begin
		ctl_d   = '0;
		sharp_d = 1'b0;
		mid_d   = job.mid;
		take    = 1'b0;
		phase_d = phase_q;
		if (job_valid) begin
			if (!phase_q && job.emit1) begin
				ctl_d.live = 1'b1;
				ctl_d.vld  = 1'b1;
				ctl_d.clr  = job.clr;
				sharp_d    = job.sharp;
				if (job.emit2) begin
					phase_d = 1'b1;
				end else begin
					take = 1'b1;
				end
			end else begin
				// also a bubble that only carries the bin clear
				ctl_d.live = 1'b1;
				ctl_d.vld  = job.emit2;
				ctl_d.clr  = job.clr && !phase_q;
				ctl_d.last = job.last;
				mid_d      = job.down;
				take       = 1'b1;
				phase_d    = 1'b0;
			end
		end
	end

	assign job_take = adv && take;

	always_comb begin
		pix_f.r = sharp_ch(mid_s1.r, left_s1.r, right_s1.r, up_s1.r, down_s1.r);
		pix_f.g = sharp_ch(mid_s1.g, left_s1.g, right_s1.g, up_s1.g, down_s1.g);
		pix_f.b = sharp_ch(mid_s1.b, left_s1.b, right_s1.b, up_s1.b, down_s1.b);
	end

	always_comb begin
		if (luma_s3 < LUMA_TH0) begin
			bin_d = BIN_0;
		end else if (luma_s3 < LUMA_TH1) begin
			bin_d = BIN_1;
		end else if (luma_s3 < LUMA_TH2) begin
			bin_d = BIN_2;
		end else if (luma_s3 < LUMA_TH3) begin
			bin_d = BIN_3;
		end else begin
			bin_d = BIN_4;
		end
	end

	always_comb begin
		base = '0;
		for (int i = 0; i < NUM_BINS; i++) begin
			base = ctl_s3.clr ? '0 : cnt_q[i];
			if (ctl_s3.vld && (bin_d == BIN_W'(i)) && (base != CNT_MAX)) begin
				cnt_d[i] = base + CNT_W'(1);
			end else begin
				cnt_d[i] = base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sharp_s1 <= sharp_d;
			up_s1    <= job.up;
			left_s1  <= job.left;
			mid_s1   <= mid_d;
			right_s1 <= job.right;
			down_s1  <= job.down;
			pix_s2   <= sharp_s1 ? pix_f : mid_s1;
			pix_s3   <= pix_s2;
			luma_s3  <= LUMA_W'(WT_R) * LUMA_W'(pix_s2.r)
				+ LUMA_W'(WT_G) * LUMA_W'(pix_s2.g)
				+ LUMA_W'(WT_B) * LUMA_W'(pix_s2.b);
			if (ctl_s3.vld) begin
				out_pix_q  <= pix_s3;
				out_bin_q  <= bin_d;
				out_last_q <= ctl_s3.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NUM_BINS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (adv) begin
			phase_q   <= phase_d;
			ctl_s1    <= ctl_d;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			out_vld_q <= ctl_s3.vld;
			if (ctl_s3.live) begin
				for (int i = 0; i < NUM_BINS; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
			end
		end
	end

	// counts only move when the result register reloads or, on a frame-start clear, empties, so they track it
	assign out_r      = out_pix_q.r;
	assign out_g      = out_pix_q.g;
	assign out_b      = out_pix_q.b;
	assign grey_bin   = out_bin_q;
	assign frame_last = out_last_q;
	assign bin0_count = cnt_q[0];
	assign bin1_count = cnt_q[1];
	assign bin2_count = cnt_q[2];
	assign bin3_count = cnt_q[3];
	assign bin4_count = cnt_q[4];

endmodule
